>>> design/tpl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpl_pkg
// Shared types and constants for the timeline position lookup block.
// ----------------------------------------------------------------------------
package tpl_pkg;

  localparam int POS_W   = 40;
  localparam int PLACE_W = 28;
  localparam int DEPTH_DEFAULT = 4096;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage
`default_nettype wire

>>> design/timeline_position_lookup_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// timeline_position_lookup_core
// Sorted timeline table with floor lookup by binary search, optional wrap.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit first)                          | tuser
// in_     | in  | position[40:0], order[8], row[8], lcount[4], lrow[8] | mode[1:0]
// out_    | out | found_order, found_row, found_loop_count, found_loop_row | status
// cfg_    | in  | loop_length[39:0]                              | -
//
// Append, clear and unused mode: result valid the cycle after accept.
// Lookup: a modulo when wrapping applies, then bisection probes, each a
//   probe state and a compare state (registered memory read), at most 13
//   probes at depth 4096, then one state to end the search and one to
//   fetch the place before the result is shown.
// One item at a time; in_tready is low while an item is in work or its
//   result waits on out_tready.
// Reset clears entry count, loop length and control; table contents are
//   left as they are.
// ----------------------------------------------------------------------------
module timeline_position_lookup_core
  import tpl_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
)(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,  // position, order_index, row_index, loop_count, loop_row
  input  wire logic [1:0]  in_tuser,  // mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata, // found_order, found_row, found_loop_count, found_loop_row
  output logic [1:0]       out_tuser, // status
  input  wire logic        cfg_we,
  input  wire logic [39:0] cfg_wdata  // loop_length
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MOD   = 6'b000010,
    S_PROBE = 6'b000100,
    S_CMP   = 6'b001000,
    S_FETCH = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [POS_W-1:0] loop_len_r;
  logic [CW-1:0]    count_r, count_nxt;
  logic [POS_W-1:0] query_r, query_nxt;
  logic [CW-1:0]    lo_r, lo_nxt, hi_r, hi_nxt;
  logic [AW-1:0]    mid_r, mid_nxt, hit_r, hit_nxt;
  logic [1:0]       st_r, st_nxt;
  logic [PLACE_W-1:0] place_r, place_nxt;

  // decoded input
  logic             acc;
  logic [POS_W-1:0] in_pos;
  logic [PLACE_W-1:0] in_place;
  assign acc      = in_tvalid && in_tready;
  assign in_pos   = in_tdata[40] ? '0 : in_tdata[39:0];
  assign in_place = in_tdata[68:41];
  assign in_tready = (state_r == S_IDLE);

  // memory port
  logic             mem_we;
  logic [AW-1:0]    mem_addr;
  logic [POS_W-1:0] rpos;
  logic [PLACE_W-1:0] rplace;

  tpl_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_mem (
    .clk(clk), .we(mem_we), .addr(mem_addr),
    .wpos(in_pos), .wplace(in_place), .rpos(rpos), .rplace(rplace)
  );

  // modulo unit
  logic mod_start, mod_done;
  logic [POS_W-1:0] mod_rem;
  tpl_mod u_mod (
    .clk(clk), .rst_n(rst_n), .start(mod_start), .num(in_pos),
    .den(loop_len_r), .done(mod_done), .rem(mod_rem)
  );

  logic [CW-1:0] mid_w;  // lo + (hi-lo)/2, both within count
  assign mid_w = lo_r + ((hi_r - lo_r) >> 1);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    query_nxt = query_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    hit_nxt   = hit_r;
    st_nxt    = st_r;
    place_nxt = place_r;
    mem_we    = 1'b0;
    mem_addr  = mid_r;
    mod_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        mem_addr = count_r[AW-1:0];
        if (acc) begin
          st_nxt    = ST_OK;
          place_nxt = '0;
          query_nxt = in_pos;
          lo_nxt    = '0;
          hi_nxt    = count_r - 1'b1;
          hit_nxt   = '0;
          state_nxt = S_OUT;
          unique case (mode_t'(in_tuser))
            MODE_APPEND: begin
              if (count_r >= CW'(TABLE_DEPTH)) st_nxt = ST_FULL;
              else begin
                mem_we    = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            MODE_CLEAR: count_nxt = '0;
            MODE_LOOKUP: begin
              if (count_r == '0) st_nxt = ST_EMPTY;
              else if (loop_len_r != '0 && in_pos >= loop_len_r) begin
                mod_start = 1'b1;
                state_nxt = S_MOD;
              end else state_nxt = S_PROBE;
            end
            default: ;
          endcase
        end
      end
      S_MOD: if (mod_done) begin
        query_nxt = mod_rem;
        state_nxt = S_PROBE;
      end
      S_PROBE: begin
        if (lo_r > hi_r) begin
          mem_addr  = hit_r;
          state_nxt = S_FETCH;
        end else begin
          mid_nxt   = mid_w[AW-1:0];
          mem_addr  = mid_w[AW-1:0];
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_PROBE;
        if (rpos <= query_r) begin
          hit_nxt = mid_r;
          if (CW'(mid_r) == count_r - 1'b1) hi_nxt = '0;
          lo_nxt = CW'(mid_r) + 1'b1;
          if (CW'(mid_r) == count_r - 1'b1) lo_nxt = CW'(1);
        end else begin
          if (mid_r == '0) begin
            lo_nxt = CW'(1);
            hi_nxt = '0;
          end else hi_nxt = CW'(mid_r) - 1'b1;
        end
      end
      S_FETCH: begin
        place_nxt = rplace;
        state_nxt = S_OUT;
      end
      S_OUT: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      loop_len_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_we) loop_len_r <= cfg_wdata;
    end
    query_r <= query_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    hit_r   <= hit_nxt;
    st_r    <= st_nxt;
    place_r <= place_nxt;
  end

  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {4'd0, place_r};
  assign out_tuser  = st_r;

endmodule
`default_nettype wire

>>> design/tpl_mod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpl_mod
// Bit-serial restoring modulo unit: rem = num % den, one bit per cycle.
// ----------------------------------------------------------------------------
module tpl_mod
  import tpl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [POS_W-1:0] num,
  input  wire logic [POS_W-1:0] den,
  output logic                  done,
  output logic [POS_W-1:0]      rem
);

  localparam int CNT_W = $clog2(POS_W + 1);

  logic [POS_W-1:0] q_r, q_nxt;
  logic [POS_W:0]   p_r, p_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [POS_W:0]   sh;

  always_comb begin
    q_nxt    = q_r;
    p_nxt    = p_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    sh       = {p_r[POS_W-1:0], q_r[POS_W-1]};
    if (start) begin
      q_nxt    = num;
      p_nxt    = '0;
      cnt_nxt  = CNT_W'(POS_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt = {q_r[POS_W-2:0], 1'b0};
      if (sh >= {1'b0, den}) p_nxt = sh - {1'b0, den};
      else                   p_nxt = sh;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    p_r <= p_nxt;
  end

  assign done = busy_r && (cnt_r == CNT_W'(1));
  assign rem  = p_nxt[POS_W-1:0];

endmodule
`default_nettype wire

>>> design/tpl_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpl_mem
// Entry table: position and place, one registered read per cycle and an optional write to the same address.
// ----------------------------------------------------------------------------
module tpl_mem
  import tpl_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT,
  localparam int AW = $clog2(TABLE_DEPTH)
)(
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [AW-1:0]      addr,
  input  wire logic [POS_W-1:0]   wpos,
  input  wire logic [PLACE_W-1:0] wplace,
  output logic [POS_W-1:0]        rpos,
  output logic [PLACE_W-1:0]      rplace
);

  logic [POS_W+PLACE_W-1:0] mem [TABLE_DEPTH];
  logic [POS_W+PLACE_W-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= {wplace, wpos};
    rd_r <= mem[addr];
  end

  assign rpos   = rd_r[POS_W-1:0];
  assign rplace = rd_r[POS_W+PLACE_W-1:POS_W];

endmodule
`default_nettype wire

>>> design/tpl_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpl_checker
// Port-level checks for the timeline lookup core.
// ----------------------------------------------------------------------------
module tpl_checker
  import tpl_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken with result pending");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= ST_FULL) else $error("bad status");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == '0) else $error("err data");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");

endmodule

bind timeline_position_lookup_core tpl_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);
`default_nettype wire
